### hw/rtl/dswa_pkg.sv
// Shared constants, codes and types for the detection statistics window average block.
`timescale 1ns / 1ps

package dswa_pkg;

  localparam int WINDOW_DEPTH = 50;
  localparam int WIDTH_BITS   = 10;

  localparam int CNT_W   = 32;
  localparam int CODE_W  = 3;
  localparam int MODE_W  = 2;
  localparam int SCALE_W = 16;
  localparam int SUM_W   = 42;
  localparam int FRAC_W  = 4;
  localparam int MEAN_W  = 14;
  localparam int FOCAL_W = 22;
  localparam int SCALE_FRAC_W = 8;
  localparam int PROD_W  = MEAN_W + SCALE_W;

  localparam int POS_W  = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int RSUM_W = WIDTH_BITS + FILL_W;

  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(MEAN_W);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CUM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WIN   = 2'd2;

  localparam logic [CODE_W-1:0] REASON_AREA = 3'd1;
  localparam logic [CODE_W-1:0] REASON_FILL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 4'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd2560;
  localparam logic [MEAN_W-1:0]  MEAN_MAX    = {MEAN_W{1'b1}};

  typedef struct packed {
    logic              done;
    logic              hold;
    logic [MEAN_W-1:0] quot;
  } div_status_t;

endpackage

### hw/rtl/dswa_if.sv
// Request channel interfaces: input item, result item and register write.
`timescale 1ns / 1ps

interface dswa_in_if;
  logic                           valid;
  logic                           ready;
  logic                           frame_valid;
  logic [dswa_pkg::WIDTH_BITS-1:0] width_pixels;
  logic [dswa_pkg::CODE_W-1:0]    reject_code;
  modport source (output valid, frame_valid, width_pixels, reject_code, input ready);
  modport sink   (input valid, frame_valid, width_pixels, reject_code, output ready);
endinterface

interface dswa_out_if;
  logic                         valid;
  logic                         ready;
  logic [dswa_pkg::CNT_W-1:0]   frames_seen;
  logic [dswa_pkg::CNT_W-1:0]   frames_valid;
  logic [dswa_pkg::CNT_W-1:0]   area_rejects;
  logic [dswa_pkg::CNT_W-1:0]   width_rejects;
  logic [dswa_pkg::CNT_W-1:0]   aspect_rejects;
  logic [dswa_pkg::CNT_W-1:0]   fill_rejects;
  logic [dswa_pkg::MEAN_W-1:0]  mean_width;
  logic [dswa_pkg::FOCAL_W-1:0] focal_pixels;
  logic [dswa_pkg::CNT_W-1:0]   width_samples;
  modport source (output valid, frames_seen, frames_valid, area_rejects, width_rejects,
                  aspect_rejects, fill_rejects, mean_width, focal_pixels, width_samples,
                  input ready);
  modport sink   (input valid, frames_seen, frames_valid, area_rejects, width_rejects,
                  aspect_rejects, fill_rejects, mean_width, focal_pixels, width_samples,
                  output ready);
endinterface

interface dswa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dswa_pkg::CFG_IDX_W-1:0]  index;
  logic [dswa_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/dswa_div.sv
// Serial divider for the Q.4 mean: floor(16 * num / den), saturated, held on zero divisor.
`timescale 1ns / 1ps

module dswa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dswa_pkg::SUM_W-1:0]  num,
  input  logic [dswa_pkg::CNT_W-1:0]  den,
  output dswa_pkg::div_status_t       status
);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} dstate_t;

  dstate_t                       state;
  logic [dswa_pkg::SUM_W-1:0]    num_q;
  logic [dswa_pkg::CNT_W-1:0]    den_q;
  logic [dswa_pkg::DIV_W-1:0]    rem;
  logic [dswa_pkg::DIV_W-1:0]    dsh;
  logic [dswa_pkg::MEAN_W-1:0]   quot;
  logic [dswa_pkg::STEP_W-1:0]   step;
  logic                          fits;
  logic [dswa_pkg::DIV_W-1:0]    den_limit;

  assign den_limit = dswa_pkg::DIV_W'(den_q) << (dswa_pkg::MEAN_W - dswa_pkg::FRAC_W);
  assign fits      = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= D_IDLE;
      status.done <= 1'b0;
    end else begin
      unique case (state)
        D_IDLE: begin
          status.done <= 1'b0;
          if (start) begin
            num_q <= num;
            den_q <= den;
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (den_q == '0) begin
            status.done <= 1'b1;
            status.hold <= 1'b1;
            state       <= D_IDLE;
          end else if (dswa_pkg::DIV_W'(num_q) >= den_limit) begin
            status.done <= 1'b1;
            status.hold <= 1'b0;
            status.quot <= dswa_pkg::MEAN_MAX;
            state       <= D_IDLE;
          end else begin
            status.done <= 1'b0;
            rem   <= dswa_pkg::DIV_W'(num_q) << dswa_pkg::FRAC_W;
            dsh   <= dswa_pkg::DIV_W'(den_q) << (dswa_pkg::MEAN_W - 1);
            quot  <= '0;
            step  <= dswa_pkg::STEP_W'(dswa_pkg::MEAN_W - 1);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (fits) begin
            rem <= rem - dsh;
          end
          dsh  <= dsh >> 1;
          quot <= {quot[dswa_pkg::MEAN_W-2:0], fits};
          step <= step - 1'b1;
          status.done <= (step == '0);
          if (step == '0) begin
            status.hold <= 1'b0;
            status.quot <= {quot[dswa_pkg::MEAN_W-2:0], fits};
            state       <= D_IDLE;
          end
        end
        default: begin
          status.done <= 1'b0;
          state       <= D_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/detection_stats_window_average.sv
// Top level: frame counters, width ring memory, mean sequencer and focal estimate.
//
//   channel  dir  request carries
//   in_ch    in   frame_valid, width_pixels, reject_code
//   out_ch   out  counters, mean_width, focal_pixels, width_samples
//   cfg      in   index (0 average_mode, 1 focal_scale), data
//
// One request at a time; a request that takes a width (cumulative or window mode)
// waits on the 14-step serial divider, which stops early when the mean saturates.
// The ring is read at accept and written back in the next cycle.
// Reset is synchronous; ring slots carry valid bits, so no clearing pass.
// The result waits in an output register; a new request is taken while it stalls.
`timescale 1ns / 1ps

module detection_stats_window_average (
  input logic       clk,
  input logic       rst,
  dswa_in_if.sink   in_ch,
  dswa_out_if.source out_ch,
  dswa_cfg_if.sink  cfg
);

  typedef enum logic [2:0] {S_IDLE, S_RING, S_START, S_WAIT, S_MUL, S_FOC, S_DONE} state_t;

  state_t                              state;
  logic [dswa_pkg::MODE_W-1:0]         average_mode;
  logic [dswa_pkg::SCALE_W-1:0]        focal_scale;
  logic [dswa_pkg::CNT_W-1:0]          frame_cnt;
  logic [dswa_pkg::CNT_W-1:0]          valid_cnt;
  logic [dswa_pkg::CNT_W-1:0]          rej_cnt [4];
  logic [dswa_pkg::SUM_W-1:0]          cum_sum;
  logic [dswa_pkg::CNT_W-1:0]          sample_cnt;
  logic [dswa_pkg::POS_W-1:0]          ring_pos;
  logic [dswa_pkg::RSUM_W-1:0]         ring_sum;
  logic [dswa_pkg::FILL_W-1:0]         ring_filled;
  logic [dswa_pkg::WINDOW_DEPTH-1:0]   slot_valid;
  logic [dswa_pkg::MEAN_W-1:0]         mean_reg;
  logic [dswa_pkg::FOCAL_W-1:0]        focal_reg;
  logic [dswa_pkg::WIDTH_BITS-1:0]     item_width;
  logic                                win_path;
  logic [dswa_pkg::SUM_W-1:0]          div_num;
  logic [dswa_pkg::CNT_W-1:0]          div_den;
  logic [dswa_pkg::PROD_W-1:0]         prod;
  logic                                out_valid;

  logic [dswa_pkg::WIDTH_BITS-1:0]     ring_mem [dswa_pkg::WINDOW_DEPTH];
  logic [dswa_pkg::WIDTH_BITS-1:0]     ring_rdata;
  logic                                ring_we;

  logic                                in_acc;
  logic                                take_width;
  logic [dswa_pkg::SUM_W-1:0]          cum_sum_next;
  logic [dswa_pkg::CNT_W-1:0]          sample_cnt_next;
  logic [dswa_pkg::WIDTH_BITS-1:0]     old_width;
  logic [dswa_pkg::RSUM_W-1:0]         ring_sum_next;
  logic [dswa_pkg::FILL_W-1:0]         ring_filled_next;
  logic [dswa_pkg::POS_W-1:0]          ring_pos_next;
  logic [1:0]                          rej_idx;
  logic                                rej_hit;
  logic                                out_free;
  dswa_pkg::div_status_t               div_st;

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;

  assign take_width = in_ch.frame_valid && (in_ch.width_pixels != '0) &&
                      ((average_mode == dswa_pkg::MODE_CUM) ||
                       (average_mode == dswa_pkg::MODE_WIN));
  assign cum_sum_next    = cum_sum + dswa_pkg::SUM_W'(in_ch.width_pixels);
  assign sample_cnt_next = sample_cnt + 1'b1;
  assign rej_hit = !in_ch.frame_valid && (in_ch.reject_code >= dswa_pkg::REASON_AREA) &&
                   (in_ch.reject_code <= dswa_pkg::REASON_FILL);
  assign rej_idx = 2'(in_ch.reject_code - dswa_pkg::REASON_AREA);

  assign old_width        = slot_valid[ring_pos] ? ring_rdata : '0;
  assign ring_sum_next    = ring_sum - dswa_pkg::RSUM_W'(old_width)
                            + dswa_pkg::RSUM_W'(item_width);
  assign ring_filled_next = ring_filled + dswa_pkg::FILL_W'(old_width == '0);
  assign ring_pos_next    = (ring_pos == dswa_pkg::POS_W'(dswa_pkg::WINDOW_DEPTH - 1)) ?
                            '0 : ring_pos + 1'b1;
  assign ring_we          = (state == S_RING);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_pos] <= item_width;
    end
    ring_rdata <= ring_mem[ring_pos];
  end

  dswa_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_START),
    .num    (div_num),
    .den    (div_den),
    .status (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      average_mode <= dswa_pkg::MODE_WIN;
      focal_scale  <= dswa_pkg::SCALE_RESET;
      frame_cnt    <= '0;
      valid_cnt    <= '0;
      for (int i = 0; i < 4; i++) rej_cnt[i] <= '0;
      cum_sum      <= '0;
      sample_cnt   <= '0;
      ring_pos     <= '0;
      ring_sum     <= '0;
      ring_filled  <= '0;
      slot_valid   <= '0;
      mean_reg     <= '0;
      focal_reg    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          dswa_pkg::REG_MODE: begin
            average_mode <= cfg.data[dswa_pkg::MODE_W-1:0];
          end
          dswa_pkg::REG_SCALE: begin
            focal_scale <= cfg.data[dswa_pkg::SCALE_W-1:0];
          end
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            item_width <= in_ch.width_pixels;
            frame_cnt  <= frame_cnt + 1'b1;
            if (in_ch.frame_valid) begin
              valid_cnt <= valid_cnt + 1'b1;
            end
            if (rej_hit) begin
              rej_cnt[rej_idx] <= rej_cnt[rej_idx] + 1'b1;
            end
            win_path <= average_mode == dswa_pkg::MODE_WIN;
            if (take_width) begin
              cum_sum    <= cum_sum_next;
              sample_cnt <= sample_cnt_next;
              div_num    <= cum_sum_next;
              div_den    <= sample_cnt_next;
              state      <= (average_mode == dswa_pkg::MODE_WIN) ? S_RING : S_START;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RING: begin
          slot_valid[ring_pos] <= 1'b1;
          ring_sum    <= ring_sum_next;
          ring_filled <= ring_filled_next;
          ring_pos    <= ring_pos_next;
          div_num     <= dswa_pkg::SUM_W'(ring_sum_next);
          div_den     <= dswa_pkg::CNT_W'(ring_filled_next);
          state       <= S_START;
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (div_st.done) begin
            if (!div_st.hold) begin
              mean_reg <= div_st.quot;
            end
            state <= win_path ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          prod  <= dswa_pkg::PROD_W'(mean_reg) * dswa_pkg::PROD_W'(focal_scale);
          state <= S_FOC;
        end
        S_FOC: begin
          focal_reg <= prod[dswa_pkg::SCALE_FRAC_W +: dswa_pkg::FOCAL_W];
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_ch.frames_seen    <= frame_cnt;
            out_ch.frames_valid   <= valid_cnt;
            out_ch.area_rejects   <= rej_cnt[0];
            out_ch.width_rejects  <= rej_cnt[1];
            out_ch.aspect_rejects <= rej_cnt[2];
            out_ch.fill_rejects   <= rej_cnt[3];
            out_ch.mean_width     <= mean_reg;
            out_ch.focal_pixels   <= focal_reg;
            out_ch.width_samples  <= sample_cnt;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ring_filled <= dswa_pkg::FILL_W'(dswa_pkg::WINDOW_DEPTH))
    else $error("ring fill count beyond window depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    ring_pos <= dswa_pkg::POS_W'(dswa_pkg::WINDOW_DEPTH - 1))
    else $error("ring position out of range");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("second request taken while one is in work");

  a_div_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && div_st.done && win_path) |-> !div_st.hold)
    else $error("window mean held with a filled ring");
`endif

endmodule

### dv/dswa_stats_checker.sv
// Checker: mirrors frame counters and width averages, compares every result request.
`timescale 1ns / 1ps

module dswa_stats_checker (
  input  logic clk,
  input  logic rst,
  dswa_in_if   in_mon,
  dswa_out_if  out_mon,
  dswa_cfg_if  cfg_mon,
  output int   fail_count,
  output int   outstanding
);

  localparam logic [dswa_pkg::FOCAL_W-1:0] FOCAL_MAX = {dswa_pkg::FOCAL_W{1'b1}};

  typedef struct packed {
    logic [dswa_pkg::CNT_W-1:0]   frames_seen;
    logic [dswa_pkg::CNT_W-1:0]   frames_valid;
    logic [dswa_pkg::CNT_W-1:0]   area_rejects;
    logic [dswa_pkg::CNT_W-1:0]   width_rejects;
    logic [dswa_pkg::CNT_W-1:0]   aspect_rejects;
    logic [dswa_pkg::CNT_W-1:0]   fill_rejects;
    logic [dswa_pkg::MEAN_W-1:0]  mean_width;
    logic [dswa_pkg::FOCAL_W-1:0] focal_pixels;
    logic [dswa_pkg::CNT_W-1:0]   width_samples;
  } frame_stats_t;

  frame_stats_t stats_q[$];

  logic [dswa_pkg::MODE_W-1:0]     cur_mode;
  logic [dswa_pkg::SCALE_W-1:0]    cur_scale;
  logic [dswa_pkg::CNT_W-1:0]      frame_cnt;
  logic [dswa_pkg::CNT_W-1:0]      valid_cnt;
  logic [dswa_pkg::CNT_W-1:0]      rej_cnt[4];
  logic [dswa_pkg::CNT_W-1:0]      sample_cnt;
  logic [dswa_pkg::SUM_W-1:0]      cum_sum;
  logic [dswa_pkg::WIDTH_BITS-1:0] ring[dswa_pkg::WINDOW_DEPTH];
  int unsigned                     ring_pos;
  int unsigned                     ring_fill;
  logic [31:0]                     ring_total;
  logic [dswa_pkg::MEAN_W-1:0]     mean_q4;
  logic [dswa_pkg::FOCAL_W-1:0]    focal_q4;
  int                              err_cnt = 0;

  assign fail_count = err_cnt;

  task automatic log_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      log_error($sformatf("%s got 0x%0h want 0x%0h (frame %0d)", name, got, want,
                          out_mon.frames_seen));
  endtask

  function automatic frame_stats_t next_stats(logic fv, logic [dswa_pkg::WIDTH_BITS-1:0] w,
                                              logic [dswa_pkg::CODE_W-1:0] code);
    logic [63:0]  quot;
    logic [63:0]  prod;
    frame_stats_t s;
    frame_cnt++;
    if (fv) begin
      valid_cnt++;
      if (w != 0 && (cur_mode == dswa_pkg::MODE_CUM || cur_mode == dswa_pkg::MODE_WIN)) begin
        cum_sum = cum_sum + dswa_pkg::SUM_W'(w);
        sample_cnt++;
        if (cur_mode == dswa_pkg::MODE_CUM) begin
          if (sample_cnt != 0) begin
            quot = {18'b0, cum_sum, 4'b0} / {32'b0, sample_cnt};
            mean_q4 = (quot > 64'(dswa_pkg::MEAN_MAX)) ? dswa_pkg::MEAN_MAX :
                      quot[dswa_pkg::MEAN_W-1:0];
          end
        end else begin
          if (ring[ring_pos] == 0) ring_fill++;
          ring_total = ring_total - 32'(ring[ring_pos]) + 32'(w);
          ring[ring_pos] = w;
          ring_pos = (ring_pos == dswa_pkg::WINDOW_DEPTH - 1) ? 0 : ring_pos + 1;
          quot = {28'b0, ring_total, 4'b0} / 64'(ring_fill);
          mean_q4 = (quot > 64'(dswa_pkg::MEAN_MAX)) ? dswa_pkg::MEAN_MAX :
                    quot[dswa_pkg::MEAN_W-1:0];
          prod = (64'(mean_q4) * 64'(cur_scale)) >> dswa_pkg::SCALE_FRAC_W;
          focal_q4 = (prod > 64'(FOCAL_MAX)) ? FOCAL_MAX : prod[dswa_pkg::FOCAL_W-1:0];
        end
      end
    end else if (code >= dswa_pkg::REASON_AREA && code <= dswa_pkg::REASON_FILL) begin
      rej_cnt[code - dswa_pkg::REASON_AREA]++;
    end
    s.frames_seen    = frame_cnt;
    s.frames_valid   = valid_cnt;
    s.area_rejects   = rej_cnt[0];
    s.width_rejects  = rej_cnt[1];
    s.aspect_rejects = rej_cnt[2];
    s.fill_rejects   = rej_cnt[3];
    s.mean_width     = mean_q4;
    s.focal_pixels   = focal_q4;
    s.width_samples  = sample_cnt;
    return s;
  endfunction

  always @(posedge clk) begin
    frame_stats_t want;
    if (rst) begin
      cur_mode   = dswa_pkg::MODE_WIN;
      cur_scale  = dswa_pkg::SCALE_RESET;
      frame_cnt  = '0;
      valid_cnt  = '0;
      sample_cnt = '0;
      cum_sum    = '0;
      ring_pos   = 0;
      ring_fill  = 0;
      ring_total = '0;
      mean_q4    = '0;
      focal_q4   = '0;
      foreach (rej_cnt[i]) rej_cnt[i] = '0;
      foreach (ring[i]) ring[i] = '0;
      stats_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          dswa_pkg::REG_MODE:  cur_mode = cfg_mon.data[dswa_pkg::MODE_W-1:0];
          dswa_pkg::REG_SCALE: cur_scale = cfg_mon.data[dswa_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        stats_q.push_back(next_stats(in_mon.frame_valid, in_mon.width_pixels,
                                     in_mon.reject_code));
      if (out_mon.valid && out_mon.ready) begin
        if (stats_q.size() == 0) begin
          log_error("result request with no frame pending");
        end else begin
          want = stats_q.pop_front();
          check_field("frames_seen", 64'(out_mon.frames_seen), 64'(want.frames_seen));
          check_field("frames_valid", 64'(out_mon.frames_valid), 64'(want.frames_valid));
          check_field("area_rejects", 64'(out_mon.area_rejects), 64'(want.area_rejects));
          check_field("width_rejects", 64'(out_mon.width_rejects),
                      64'(want.width_rejects));
          check_field("aspect_rejects", 64'(out_mon.aspect_rejects),
                      64'(want.aspect_rejects));
          check_field("fill_rejects", 64'(out_mon.fill_rejects), 64'(want.fill_rejects));
          check_field("mean_width", 64'(out_mon.mean_width), 64'(want.mean_width));
          check_field("focal_pixels", 64'(out_mon.focal_pixels), 64'(want.focal_pixels));
          check_field("width_samples", 64'(out_mon.width_samples),
                      64'(want.width_samples));
        end
      end
    end
    outstanding <= stats_q.size();
  end

endmodule

### dv/tb_top.sv
// Testbench top: clock, reset, frame and register stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF    = 300;
  localparam logic [dswa_pkg::MODE_W-1:0]     MODE_UNDEF      = 2'd3;
  localparam logic [dswa_pkg::CFG_IDX_W-1:0]  UNMAPPED_REG_LO = dswa_pkg::REG_SCALE + 1'b1;
  localparam logic [dswa_pkg::CFG_IDX_W-1:0]  UNMAPPED_REG_HI = {dswa_pkg::CFG_IDX_W{1'b1}};
  localparam logic [dswa_pkg::SCALE_W-1:0]    SCALE_MAX       = {dswa_pkg::SCALE_W{1'b1}};
  localparam logic [dswa_pkg::WIDTH_BITS-1:0] WIDTH_MAX       = {dswa_pkg::WIDTH_BITS{1'b1}};

  logic clk;
  logic rst;
  logic calm;
  logic squeeze;
  int   fail_count;
  int   outstanding;
  int   idle_cycles;

  dswa_in_if  in_ch ();
  dswa_out_if out_ch ();
  dswa_cfg_if cfg ();

  detection_stats_window_average dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  dswa_stats_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int hold;
    bit squeezed;
    hold = 0;
    squeezed = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        hold = HOLD_OFF;
        squeezed = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_frame(logic fv, logic [dswa_pkg::WIDTH_BITS-1:0] w,
                            logic [dswa_pkg::CODE_W-1:0] code);
    int gap;
    if (!calm && $urandom_range(99) < 33) begin
      gap = $urandom_range(1, 30);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.frame_valid  <= fv;
    in_ch.width_pixels <= w;
    in_ch.reject_code  <= code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_frame();
    logic                            fv;
    logic [dswa_pkg::WIDTH_BITS-1:0] w;
    logic [dswa_pkg::CODE_W-1:0]     code;
    code = dswa_pkg::CODE_W'($urandom_range(0, (1 << dswa_pkg::CODE_W) - 1));
    if ($urandom_range(99) < 70) begin
      fv = 1'b1;
      case ($urandom_range(0, 4))
        0:       w = WIDTH_MAX;
        1:       w = dswa_pkg::WIDTH_BITS'($urandom_range(1, 15));
        default: w = dswa_pkg::WIDTH_BITS'($urandom_range(1, WIDTH_MAX));
      endcase
    end else begin
      fv = 1'($urandom_range(0, 1));
      w  = dswa_pkg::WIDTH_BITS'($urandom);
    end
    send_frame(fv, w, code);
  endtask

  task automatic cfg_write(logic [dswa_pkg::CFG_IDX_W-1:0] idx,
                           logic [dswa_pkg::CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // registers change only with the block drained
  task automatic apply_settings(logic [dswa_pkg::MODE_W-1:0] mode,
                                logic [dswa_pkg::SCALE_W-1:0] scale, bit junk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (junk) begin
      cfg_write(UNMAPPED_REG_HI, SCALE_MAX);
      cfg_write(UNMAPPED_REG_LO, '0);
    end
    cfg_write(dswa_pkg::REG_MODE,
              {(dswa_pkg::CFG_DATA_W - dswa_pkg::MODE_W)'($urandom), mode});
    cfg_write(dswa_pkg::REG_SCALE, scale);
    cfg.valid <= 1'b0;
  endtask

  task automatic run_phase(logic [dswa_pkg::MODE_W-1:0] mode,
                           logic [dswa_pkg::SCALE_W-1:0] scale, int n,
                           bit no_idle, bit hold_off);
    apply_settings(mode, scale, 1'b0);
    calm    <= no_idle;
    squeeze <= hold_off;
    @(posedge clk);
    repeat (n) send_random_frame();
    calm    <= 1'b0;
    squeeze <= 1'b0;
  endtask

  initial begin
    rst                <= 1'b1;
    calm               <= 1'b0;
    squeeze            <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.frame_valid  <= 1'b0;
    in_ch.width_pixels <= '0;
    in_ch.reject_code  <= '0;
    cfg.valid          <= 1'b0;
    cfg.index          <= '0;
    cfg.data           <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window mode, default scale; every reject code incl. unknown ones
    for (int c = 0; c < (1 << dswa_pkg::CODE_W); c++)
      send_frame(1'b0, (c % 2 == 0) ? WIDTH_MAX : '0, dswa_pkg::CODE_W'(c));
    send_frame(1'b1, '0, '1);
    send_frame(1'b1, WIDTH_MAX, '0);
    send_frame(1'b1, 10'd1, '0);
    send_frame(1'b1, WIDTH_MAX, '1);
    send_frame(1'b1, 10'd512, dswa_pkg::REASON_AREA);

    apply_settings(dswa_pkg::MODE_CUM, SCALE_MAX, 1'b1);
    send_frame(1'b1, WIDTH_MAX, '0);
    send_frame(1'b1, 10'd1, '0);
    send_frame(1'b1, 10'd341, dswa_pkg::REASON_FILL);

    apply_settings(dswa_pkg::MODE_COUNT, '0, 1'b0);
    send_frame(1'b1, 10'd700, '0);
    send_frame(1'b0, '0, dswa_pkg::REASON_FILL);

    apply_settings(MODE_UNDEF, dswa_pkg::SCALE_RESET, 1'b0);
    send_frame(1'b1, 10'd5, '0);
    send_frame(1'b0, 10'd5, dswa_pkg::REASON_AREA + 1'b1);

    apply_settings(dswa_pkg::MODE_WIN, SCALE_MAX, 1'b0);
    send_frame(1'b1, WIDTH_MAX, '0);
    send_frame(1'b1, WIDTH_MAX, '0);

    apply_settings(dswa_pkg::MODE_WIN, '0, 1'b0);
    send_frame(1'b1, 10'd3, '0);

    run_phase(dswa_pkg::MODE_WIN, dswa_pkg::SCALE_W'($urandom), 120, 1'b1, 1'b0);
    run_phase(dswa_pkg::MODE_WIN, dswa_pkg::SCALE_RESET, 100, 1'b0, 1'b1);
    run_phase(dswa_pkg::MODE_CUM, dswa_pkg::SCALE_W'($urandom), 80, 1'b0, 1'b0);
    run_phase(dswa_pkg::MODE_COUNT, dswa_pkg::SCALE_W'($urandom), 40, 1'b0, 1'b0);
    run_phase(MODE_UNDEF, dswa_pkg::SCALE_W'($urandom), 30, 1'b0, 1'b0);
    run_phase(dswa_pkg::MODE_WIN, SCALE_MAX, 80, 1'b0, 1'b0);
    run_phase(dswa_pkg::MODE_CUM, '0, 50, 1'b0, 1'b0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
